/* rtl/rlps_pkg.sv */
package rlps_pkg;

    // default configuration
    localparam int COORD_BITS_DEF  = 16;
    localparam int MAX_ENTRIES_DEF = 64;

    // fixed field widths at the ports
    localparam int COORD_IN_W = 16;
    localparam int SEED_W     = 6;

    // split axis codes
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // seed indices of both axes and set status, carried along the result path
    typedef struct packed {
        logic [SEED_W-1:0] hl_x;
        logic [SEED_W-1:0] lh_x;
        logic [SEED_W-1:0] hl_y;
        logic [SEED_W-1:0] lh_y;
        logic              same_x;
        logic              same_y;
        logic              overflow;
    } seed_info_t;

endpackage

/* rtl/rtree_linear_pick_seeds.sv */
// Linear seed picking for an R-tree node split. Rectangles of one node enter
// one request per cycle as corner, width, height and a last mark; entry
// indices count from 0 in arrival order. Per axis the block keeps the total
// extent and the entries with the highest low side and the lowest high side
// (earliest entry wins ties). On the last request it picks the axis with the
// larger separation over extent (Y on a tie, zero extent counts as zero) and
// returns that axis and its two seeds as one result, then starts a new set.
// Entries beyond MAX_ENTRIES are ignored and flagged. Rate: one rectangle per
// cycle while not stalled; the result passes from the last rectangle through
// the input register, set snapshot, cross products and result register. A
// last rectangle stalls only while the snapshot and product registers and the
// result register are all held by earlier results.
module rtree_linear_pick_seeds #(
    parameter int COORD_BITS  = rlps_pkg::COORD_BITS_DEF,
    parameter int MAX_ENTRIES = rlps_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rlps_pkg::COORD_IN_W-1:0] x_low,
    input  logic [rlps_pkg::COORD_IN_W-1:0] y_low,
    input  logic [rlps_pkg::COORD_IN_W-1:0] x_extent,
    input  logic [rlps_pkg::COORD_IN_W-1:0] y_extent,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            split_axis,
    output logic [rlps_pkg::SEED_W-1:0]     seed_high_low,
    output logic [rlps_pkg::SEED_W-1:0]     seed_low_high,
    output logic                            seeds_same,
    output logic                            overflowed
);

    logic                         fin_valid;
    logic                         fin_ready;
    logic signed [COORD_BITS+1:0] fin_nx, fin_ny;
    logic [COORD_BITS:0]          fin_dx, fin_dy;
    rlps_pkg::seed_info_t         fin_info;

    // running extremes and set snapshot
    rlps_track #(
        .CB  (COORD_BITS),
        .MAX (MAX_ENTRIES)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_low     (x_low),
        .y_low     (y_low),
        .x_extent  (x_extent),
        .y_extent  (y_extent),
        .last      (last),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_nx    (fin_nx),
        .fin_dx    (fin_dx),
        .fin_ny    (fin_ny),
        .fin_dy    (fin_dy),
        .fin_info  (fin_info)
    );

    // axis decision and result register
    rlps_compare #(
        .CB (COORD_BITS)
    ) u_compare (
        .clk           (clk),
        .rst_n         (rst_n),
        .fin_valid     (fin_valid),
        .fin_ready     (fin_ready),
        .fin_nx        (fin_nx),
        .fin_dx        (fin_dx),
        .fin_ny        (fin_ny),
        .fin_dy        (fin_dy),
        .fin_info      (fin_info),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .split_axis    (split_axis),
        .seed_high_low (seed_high_low),
        .seed_low_high (seed_low_high),
        .seeds_same    (seeds_same),
        .overflowed    (overflowed)
    );

`ifndef SYNTHESIS
    // input stalls only behind an occupied snapshot register
    a_stall_needs_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> fin_valid)
        else $error("input stalled with empty snapshot register");

    // a held snapshot implies a full result register
    a_snapshot_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid && !fin_ready) |-> out_valid)
        else $error("snapshot held while result register is empty");

    // a result always follows a snapshot that moved on
    a_snapshot_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid && fin_ready && !out_valid) |=> ##1 out_valid)
        else $error("snapshot lost on its way to the result register");
`endif

endmodule

/* rtl/rlps_axis.sv */
module rlps_axis #(
    parameter int CB = rlps_pkg::COORD_BITS_DEF,
    parameter int IW = 6
) (
    input  logic                 clk,
    input  logic [CB-1:0]        lo,
    input  logic [CB-1:0]        ext,
    input  logic [IW-1:0]        idx,
    input  logic                 first,
    input  logic                 en,
    output logic signed [CB+1:0] sep,
    output logic [CB:0]          span,
    output logic [IW-1:0]        hl_idx,
    output logic [IW-1:0]        lh_idx
);

    logic [CB-1:0] ll_reg, ll_next;
    logic [CB:0]   hh_reg, hh_next;
    logic [CB-1:0] hl_reg, hl_next;
    logic [IW-1:0] hli_reg, hli_next;
    logic [CB:0]   lh_reg, lh_next;
    logic [IW-1:0] lhi_reg, lhi_next;
    logic [CB:0]   hi;
    logic signed [CB+1:0] sep_raw;
    logic [CB:0]   span_raw;

    // high side of the rectangle, one bit wider so it never wraps
    assign hi = {1'b0, lo} + {1'b0, ext};

    // running extremes, strict compares keep the earliest entry
    always_comb
    begin
        ll_next  = ll_reg;
        hh_next  = hh_reg;
        hl_next  = hl_reg;
        hli_next = hli_reg;
        lh_next  = lh_reg;
        lhi_next = lhi_reg;
        if (en)
        begin
            if (first)
            begin
                ll_next  = lo;
                hh_next  = hi;
                hl_next  = lo;
                hli_next = idx;
                lh_next  = hi;
                lhi_next = idx;
            end
            else
            begin
                if (lo < ll_reg)
                begin
                    ll_next = lo;
                end
                if (hi > hh_reg)
                begin
                    hh_next = hi;
                end
                if (lo > hl_reg)
                begin
                    hl_next  = lo;
                    hli_next = idx;
                end
                if (hi < lh_reg)
                begin
                    lh_next  = hi;
                    lhi_next = idx;
                end
            end
        end
    end

    // first entry of a set loads everything, so no reset is needed
    always_ff @(posedge clk)
    begin
        ll_reg  <= ll_next;
        hh_reg  <= hh_next;
        hl_reg  <= hl_next;
        hli_reg <= hli_next;
        lh_reg  <= lh_next;
        lhi_reg <= lhi_next;
    end

    // separation and total extent including the current entry
    assign sep_raw  = $signed({2'b00, hl_next}) - $signed({1'b0, lh_next});
    assign span_raw = hh_next - {1'b0, ll_next};

    // a zero extent counts as zero separation over unit extent
    always_comb
    begin
        if (span_raw == '0)
        begin
            sep  = '0;
            span = (CB+1)'(1);
        end
        else
        begin
            sep  = sep_raw;
            span = span_raw;
        end
    end

    assign hl_idx = hli_next;
    assign lh_idx = lhi_next;

endmodule

/* rtl/rlps_track.sv */
module rlps_track #(
    parameter int CB  = rlps_pkg::COORD_BITS_DEF,
    parameter int MAX = rlps_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rlps_pkg::COORD_IN_W-1:0]   x_low,
    input  logic [rlps_pkg::COORD_IN_W-1:0]   y_low,
    input  logic [rlps_pkg::COORD_IN_W-1:0]   x_extent,
    input  logic [rlps_pkg::COORD_IN_W-1:0]   y_extent,
    input  logic                              last,
    output logic                              fin_valid,
    input  logic                              fin_ready,
    output logic signed [CB+1:0]              fin_nx,
    output logic [CB:0]                       fin_dx,
    output logic signed [CB+1:0]              fin_ny,
    output logic [CB:0]                       fin_dy,
    output rlps_pkg::seed_info_t              fin_info
);

    localparam int CW = $clog2(MAX + 1);
    localparam int IW = $clog2(MAX);
    localparam int PADW = CB + rlps_pkg::COORD_IN_W;
    localparam int SPADW = IW + rlps_pkg::SEED_W;

    // input register
    logic          in_valid_reg;
    logic [CB-1:0] xl_reg, yl_reg, xe_reg, ye_reg;
    logic          last_reg;

    // set state
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;

    // snapshot register
    logic                 fin_valid_reg, fin_valid_next;
    logic signed [CB+1:0] nx_reg, ny_reg;
    logic [CB:0]          dx_reg, dy_reg;
    rlps_pkg::seed_info_t info_reg, info_next;

    logic                 take, close, below, en, first, snap_free;
    logic [IW-1:0]        idx;
    logic signed [CB+1:0] sep_x, sep_y;
    logic [CB:0]          span_x, span_y;
    logic [IW-1:0]        hli_x, lhi_x, hli_y, lhi_y;
    logic [PADW-1:0]      xl_pad, yl_pad, xe_pad, ye_pad;
    logic [SPADW-1:0]     hlx_pad, lhx_pad, hly_pad, lhy_pad;

    // a last request waits only for room in the snapshot register
    assign snap_free = !fin_valid_reg || fin_ready;
    assign take      = in_valid_reg && (!last_reg || snap_free);
    assign close     = take && last_reg;
    assign in_stall  = in_valid_reg && last_reg && !snap_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // coordinates trimmed or widened to the working width
    assign xl_pad = {{CB{1'b0}}, x_low};
    assign yl_pad = {{CB{1'b0}}, y_low};
    assign xe_pad = {{CB{1'b0}}, x_extent};
    assign ye_pad = {{CB{1'b0}}, y_extent};

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            xl_reg   <= xl_pad[CB-1:0];
            yl_reg   <= yl_pad[CB-1:0];
            xe_reg   <= xe_pad[CB-1:0];
            ye_reg   <= ye_pad[CB-1:0];
            last_reg <= last;
        end
    end

    // entries beyond the maximum are dropped and flagged
    assign below = count_reg < CW'(MAX);
    assign en    = take && below;
    assign first = count_reg == '0;
    assign idx   = count_reg[IW-1:0];

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (close)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (take)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // per-axis trackers
    rlps_axis #(
        .CB (CB),
        .IW (IW)
    ) u_axis_x (
        .clk    (clk),
        .lo     (xl_reg),
        .ext    (xe_reg),
        .idx    (idx),
        .first  (first),
        .en     (en),
        .sep    (sep_x),
        .span   (span_x),
        .hl_idx (hli_x),
        .lh_idx (lhi_x)
    );

    rlps_axis #(
        .CB (CB),
        .IW (IW)
    ) u_axis_y (
        .clk    (clk),
        .lo     (yl_reg),
        .ext    (ye_reg),
        .idx    (idx),
        .first  (first),
        .en     (en),
        .sep    (sep_y),
        .span   (span_y),
        .hl_idx (hli_y),
        .lh_idx (lhi_y)
    );

    // seed indices reported on six bits
    assign hlx_pad = {{rlps_pkg::SEED_W{1'b0}}, hli_x};
    assign lhx_pad = {{rlps_pkg::SEED_W{1'b0}}, lhi_x};
    assign hly_pad = {{rlps_pkg::SEED_W{1'b0}}, hli_y};
    assign lhy_pad = {{rlps_pkg::SEED_W{1'b0}}, lhi_y};

    always_comb
    begin
        info_next.hl_x     = hlx_pad[rlps_pkg::SEED_W-1:0];
        info_next.lh_x     = lhx_pad[rlps_pkg::SEED_W-1:0];
        info_next.hl_y     = hly_pad[rlps_pkg::SEED_W-1:0];
        info_next.lh_y     = lhy_pad[rlps_pkg::SEED_W-1:0];
        info_next.same_x   = hli_x == lhi_x;
        info_next.same_y   = hli_y == lhi_y;
        info_next.overflow = ovf_reg || (take && !below);
    end

    // snapshot of the closed set
    always_comb
    begin
        if (close)
        begin
            fin_valid_next = 1'b1;
        end
        else if (fin_ready)
        begin
            fin_valid_next = 1'b0;
        end
        else
        begin
            fin_valid_next = fin_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            nx_reg   <= sep_x;
            dx_reg   <= span_x;
            ny_reg   <= sep_y;
            dy_reg   <= span_y;
            info_reg <= info_next;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_nx    = nx_reg;
    assign fin_dx    = dx_reg;
    assign fin_ny    = ny_reg;
    assign fin_dy    = dy_reg;
    assign fin_info  = info_reg;

endmodule

/* rtl/rlps_compare.sv */
module rlps_compare #(
    parameter int CB = rlps_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fin_valid,
    output logic                             fin_ready,
    input  logic signed [CB+1:0]             fin_nx,
    input  logic [CB:0]                      fin_dx,
    input  logic signed [CB+1:0]             fin_ny,
    input  logic [CB:0]                      fin_dy,
    input  rlps_pkg::seed_info_t             fin_info,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             split_axis,
    output logic [rlps_pkg::SEED_W-1:0]      seed_high_low,
    output logic [rlps_pkg::SEED_W-1:0]      seed_low_high,
    output logic                             seeds_same,
    output logic                             overflowed
);

    localparam int PW = 2 * CB + 2;

    logic                 prod_valid_reg;
    logic                 negx_reg, negy_reg;
    logic [PW-1:0]        pxy_reg, pyx_reg;
    rlps_pkg::seed_info_t pinfo_reg;

    logic                 out_valid_reg;
    logic                 axis_reg;
    logic [rlps_pkg::SEED_W-1:0] shl_reg, slh_reg;
    logic                 same_reg, ovf_reg;

    logic                 o_free, p_free, p_load, o_load;
    logic                 negx, negy, axis_x;
    logic [CB+1:0]        absx_w, absy_w;
    logic [CB:0]          mx, my;

    // each stage loads when it is empty or its content moves on
    assign o_free    = !out_valid_reg || !out_stall;
    assign p_free    = !prod_valid_reg || o_free;
    assign fin_ready = p_free;
    assign p_load    = fin_valid && p_free;
    assign o_load    = prod_valid_reg && o_free;

    // magnitudes of the separations
    assign negx   = fin_nx < 0;
    assign negy   = fin_ny < 0;
    assign absx_w = negx ? (CB+2)'(-fin_nx) : (CB+2)'(fin_nx);
    assign absy_w = negy ? (CB+2)'(-fin_ny) : (CB+2)'(fin_ny);
    assign mx     = absx_w[CB:0];
    assign my     = absy_w[CB:0];

    // cross products register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (p_free)
        begin
            prod_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_load)
        begin
            negx_reg  <= negx;
            negy_reg  <= negy;
            pxy_reg   <= PW'(mx) * PW'(fin_dy);
            pyx_reg   <= PW'(my) * PW'(fin_dx);
            pinfo_reg <= fin_info;
        end
    end

    // X wins only on a strictly larger normalised separation
    always_comb
    begin
        priority if (!negx_reg && negy_reg)
        begin
            axis_x = 1'b1;
        end
        else if (negx_reg && !negy_reg)
        begin
            axis_x = 1'b0;
        end
        else if (!negx_reg)
        begin
            axis_x = pxy_reg > pyx_reg;
        end
        else
        begin
            axis_x = pyx_reg > pxy_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (o_free)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            axis_reg <= axis_x ? rlps_pkg::AXIS_X : rlps_pkg::AXIS_Y;
            shl_reg  <= axis_x ? pinfo_reg.hl_x : pinfo_reg.hl_y;
            slh_reg  <= axis_x ? pinfo_reg.lh_x : pinfo_reg.lh_y;
            same_reg <= axis_x ? pinfo_reg.same_x : pinfo_reg.same_y;
            ovf_reg  <= pinfo_reg.overflow;
        end
    end

    assign out_valid     = out_valid_reg;
    assign split_axis    = axis_reg;
    assign seed_high_low = shl_reg;
    assign seed_low_high = slh_reg;
    assign seeds_same    = same_reg;
    assign overflowed    = ovf_reg;

endmodule
